@@ hw/rtl/svt_pkg.sv @@
// Shared types and codes for the sorted value table.
package svt_pkg;

   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic              ins;
      logic              rem;
      logic              clr;
      logic [DATA_W-1:0] value;
   } svt_cmd_type;

   typedef struct packed {
      logic sel;
      logic ge;
      logic match;
   } svt_flag_type;

endpackage

@@ hw/rtl/svt_cell.sv @@
// One table cell: holds an entry, compares it with the request value, shifts with neighbors.
module svt_cell
   import svt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  svt_cmd_type       cmd,
   input  logic              found,
   input  logic              prev_sel,
   input  logic [DATA_W-1:0] prev_entry,
   input  logic              prev_valid,
   input  logic [DATA_W-1:0] next_entry,
   input  logic              next_valid,
   output svt_flag_type      flag,
   output logic [DATA_W-1:0] entry,
   output logic              valid
);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              valid_ff;
   logic              valid_in;

   always_comb begin
      flag.sel   = !valid_ff || ($signed(entry_ff) > $signed(cmd.value));
      flag.ge    = valid_ff && ($signed(entry_ff) >= $signed(cmd.value));
      flag.match = valid_ff && (entry_ff == cmd.value);
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.ins) begin
         if (flag.sel && !prev_sel) begin
            entry_in = cmd.value;
            valid_in = 1'b1;
         end else if (flag.sel) begin
            entry_in = prev_entry;
            valid_in = prev_valid;
         end
      end else if (cmd.rem && found && flag.ge) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

@@ hw/rtl/sorted_value_table.sv @@
// Sorted value table: a row of compare-and-shift cells kept in ascending signed order.
// Each request (insert, remove, read at index, clear) is applied to the whole row of
// CAPACITY cells at once, and its result appears in the output register on the next
// cycle; a new request is taken every cycle while the result side keeps up. The
// cycle time is set by the signed compare in every cell together with the OR of
// all match flags that gates a remove across the row.
module sorted_value_table
   import svt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], index[35:32], zero[39:36]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_value[31:0], count[36:32], empty_res[37],
                                    // status[39:38]
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int OUTC_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int READ_N = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

   logic                 accept;
   logic [OP_W-1:0]      op;
   logic [DATA_W-1:0]    value;
   logic [INDEX_W-1:0]   index;
   svt_cmd_type          cmd;

   logic [DATA_W-1:0]    cell_entry [CAPACITY];
   logic [CAPACITY-1:0]  cell_valid;
   svt_flag_type         cell_flag  [CAPACITY];
   logic [CAPACITY-1:0]  match_vec;
   logic                 found;
   logic                 full;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic [39:0]          rsp_data_ff;
   logic [DATA_W-1:0]    rd_value;
   logic [STATUS_W-1:0]  status;
   logic                 in_range;
   logic [OUTC_W-1:0]    count_wide;

   assign op     = req_tuser;
   assign value  = req_tdata[DATA_W-1:0];
   assign index  = req_tdata[DATA_W+INDEX_W-1:DATA_W];
   assign accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign found = |match_vec;

   always_comb begin
      cmd.value = value;
      cmd.ins   = accept && (op == OP_INSERT) && !full;
      cmd.rem   = accept && (op == OP_REMOVE);
      cmd.clr   = accept && (op == OP_CLEAR);
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic              prev_sel;
         logic [DATA_W-1:0] prev_entry;
         logic              prev_valid;
         logic [DATA_W-1:0] next_entry;
         logic              next_valid;

         if (g == 0) begin : g_first
            assign prev_sel   = 1'b0;
            assign prev_entry = '0;
            assign prev_valid = 1'b0;
         end else begin : g_mid
            assign prev_sel   = cell_flag[g-1].sel;
            assign prev_entry = cell_entry[g-1];
            assign prev_valid = cell_valid[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign next_entry = '0;
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_entry = cell_entry[g+1];
            assign next_valid = cell_valid[g+1];
         end

         svt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .found      (found),
            .prev_sel   (prev_sel),
            .prev_entry (prev_entry),
            .prev_valid (prev_valid),
            .next_entry (next_entry),
            .next_valid (next_valid),
            .flag       (cell_flag[g]),
            .entry      (cell_entry[g]),
            .valid      (cell_valid[g])
         );

         assign match_vec[g] = cell_flag[g].match;
      end
   endgenerate

   assign in_range = CMP_W'(index) < CMP_W'(count_ff);

   always_comb begin
      rd_value = '0;
      for (int i = 0; i < READ_N; i++) begin
         if (index == INDEX_W'(i)) begin
            rd_value = cell_entry[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      status   = ST_OK;
      case (op)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         OP_READ: begin
            if (!in_range) begin
               status = ST_RANGE;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign count_wide = OUTC_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff[DATA_W-1:0]  <= ((op == OP_READ) && in_range) ? rd_value : '0;
         rsp_data_ff[36:32]       <= count_wide[COUNT_W-1:0];
         rsp_data_ff[37]          <= (count_in == '0);
         rsp_data_ff[39:38]       <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_CLEAR) |=> (count_ff == '0) && (cell_valid == '0))
      else $error("clear left entries behind");

   assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_INSERT) && full
      |=> $stable(cell_valid) && (count_ff == CNT_W'(CAPACITY)))
      else $error("dropped insert changed the table");

endmodule
